### rtl/smqb_pkg.sv
// Package for the segmented multi-queue buffer: request, status and
// register codes, field widths and default sizes.
// No dependencies; imported by every module of the block.
package smqb_pkg;

  // default sizes handed to the top level parameters
  localparam int STORE_DEPTH_DEF = 128;
  localparam int MAX_QUEUES_DEF  = 8;
  localparam int DATA_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int REQ_W      = 2;
  localparam int QID_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int NQ_W       = 4;
  localparam int SEG_W      = 8;
  localparam int TSIZE_W    = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ENQ   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DEQ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADQ  = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_QUEUES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE  = 2'd2;

  // register reset values
  localparam logic [NQ_W-1:0]    NUM_QUEUES_RST  = 4'd1;
  localparam logic [SEG_W-1:0]   SEGMENT_LEN_RST = 8'd128;
  localparam logic [TSIZE_W-1:0] TOTAL_SIZE_RST  = 8'd128;

endpackage

### rtl/smqb_qtab.sv
// Queue state table: head offset, tail offset and count per queue.
// Synchronous memory with a registered read and a valid bit per
// entry so that reset empties every queue at once. Uses smqb_pkg.
module smqb_qtab
  import smqb_pkg::*;
#(
  parameter int DEPTH = MAX_QUEUES_DEF,
  parameter int AW    = 3,
  parameter int EW    = 23
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata
);

  logic [EW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [EW-1:0]    rd_r;
  logic             rd_vld_r;

  // entry valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= vld_r[raddr];
      end
    end
  end

  // storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  // an entry never written reads as an empty queue
  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

### rtl/smqb_store.sv
// Shared data store holding every queue segment.
// Single port synchronous memory with a registered read. Uses smqb_pkg.
module smqb_store
  import smqb_pkg::*;
#(
  parameter int DEPTH = STORE_DEPTH_DEF,
  parameter int AW    = 7,
  parameter int DW    = DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_r;

  // write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[addr];
    end
  end

  assign rdata = rd_r;

endmodule

### rtl/smqb_mod_unit.sv
// Bit-serial remainder unit for offset wrap when an offset lies beyond
// a shrunken segment. One quotient bit per cycle. Uses smqb_pkg.
module smqb_mod_unit
  import smqb_pkg::*;
#(
  parameter int NW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] remainder
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   rem_r;
  logic [NW-1:0]   dvd_r;
  logic [NW:0]     trial;
  logic [NW-1:0]   rem_nxt;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[NW-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = NW'(trial - {1'b0, divisor});
    end else begin
      rem_nxt = NW'(trial);
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_r << 1;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

### rtl/segmented_multi_queue_buffer_unit.sv
// Segmented multi-queue buffer: several circular FIFOs in one shared store.
// Input channel in_*: one request item (enqueue, dequeue, full query or
// no operation) with a queue number and a data word.
// Result channel out_*: one item per request with status, dequeued word
// and the whole-array-full flag, held in an output register.
// Config channel cfg_*: register writes, always ready; write only while
// no request is in flight.
// Each request reads the queue state table, then in S_MEM updates it and
// writes or reads the data store; the output register is loaded in S_DONE,
// and a new item is taken only in S_IDLE, once that result is loaded. When
// an offset lies past a segment that was shrunk by a register write, the
// wrap runs through the bit-serial remainder unit in state S_MOD.
// A request is accepted while an earlier result still waits; the block
// then holds its finished result until out_ready is seen.
// Reset empties all queues at once through the state table valid bits and
// loads num_queues 1, segment_len 128, total_size 128; the data store
// is not cleared. Depends on smqb_pkg and the smqb_* submodules.
module segmented_multi_queue_buffer_unit
  import smqb_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int MAX_QUEUES  = MAX_QUEUES_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [REQ_W-1:0]             in_req_type,
  input  logic [QID_W-1:0]             in_queue_id,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [STATUS_W-1:0]          out_status,
  output logic signed [DATA_WIDTH-1:0] out_read_value,
  output logic                         out_array_full,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int QW     = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int LENW_F = $clog2(STORE_DEPTH + 1);
  localparam int LENW   = (LENW_F < 8) ? LENW_F : 8;
  localparam int OFW    = (AW < 8) ? AW : 8;
  localparam int EW     = 2 * OFW + LENW;
  localparam int SUMW   = LENW + QID_W;
  localparam int RW     = (SUMW > AW + 3) ? SUMW : AW + 3;
  localparam int TOTW   = LENW + QID_W;
  localparam int TCW    = (TOTW > TSIZE_W) ? TOTW : TSIZE_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_MEM  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]            state_r;
  logic [2:0]            state_nxt;

  // configuration registers
  logic [NQ_W-1:0]       num_queues_r;
  logic [SEG_W-1:0]      segment_len_r;
  logic [TSIZE_W-1:0]    total_size_r;

  // request in flight
  logic [REQ_W-1:0]      req_r;
  logic [QID_W-1:0]      qid_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [STATUS_W-1:0]   status_r;
  logic                  ok_r;
  logic [OFW-1:0]        head_r;
  logic [OFW-1:0]        tail_r;
  logic [LENW-1:0]       occ_r;
  logic [SUMW-1:0]       addr_sum_r;
  logic [OFW-1:0]        new_off_r;
  logic [TOTW-1:0]       tot_r;

  // result register
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [DATA_WIDTH-1:0] out_read_value_r;
  logic                  out_array_full_r;

  // evaluation signals
  logic                  in_acc;
  logic                  is_enq;
  logic                  is_deq;
  logic [LENW-1:0]       seg_use;
  logic [EW-1:0]         qtab_rd;
  logic [OFW-1:0]        rd_head;
  logic [OFW-1:0]        rd_tail;
  logic [LENW-1:0]       rd_occ;
  logic                  bad_q;
  logic [STATUS_W-1:0]   status_c;
  logic                  ok_c;
  logic [OFW-1:0]        off_sel;
  logic [LENW-1:0]       off_inc;
  logic                  need_mod;
  logic [OFW-1:0]        new_off_fast;
  logic [SUMW-1:0]       addr_sum_c;
  logic [RW-1:0]         red;
  logic [AW-1:0]         store_addr;
  logic                  mod_start;
  logic                  mod_done;
  logic [LENW-1:0]       mod_rem;
  logic                  qtab_we;
  logic [EW-1:0]         qtab_wdata;
  logic [DATA_WIDTH-1:0] store_rd;
  logic                  out_load;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign is_enq    = (req_r == REQ_ENQ);
  assign is_deq    = (req_r == REQ_DEQ);

  // segment length in use, limited to the store depth
  assign seg_use = (32'(segment_len_r) > STORE_DEPTH) ? LENW'(STORE_DEPTH)
                                                      : LENW'(segment_len_r);

  assign rd_head = qtab_rd[EW-1 -: OFW];
  assign rd_tail = qtab_rd[LENW +: OFW];
  assign rd_occ  = qtab_rd[LENW-1:0];

  // request check against the queue state just read
  always_comb begin
    bad_q    = (32'(qid_r) >= 32'(num_queues_r)) || (32'(qid_r) >= MAX_QUEUES);
    status_c = ST_OK;
    if (is_enq || is_deq) begin
      if (bad_q) begin
        status_c = ST_BADQ;
      end else if (is_enq && (rd_occ >= seg_use)) begin
        status_c = ST_FULL;
      end else if (is_deq && (rd_occ == '0)) begin
        status_c = ST_EMPTY;
      end
    end
    ok_c = (is_enq || is_deq) && (status_c == ST_OK);
  end

  // offset advance and segment address sum
  always_comb begin
    off_sel    = is_enq ? rd_tail : rd_head;
    off_inc    = LENW'(off_sel) + 1'b1;
    addr_sum_c = SUMW'(qid_r) * SUMW'(seg_use) + SUMW'(off_sel);
    need_mod   = ok_c && (seg_use != '0) && (off_inc > seg_use);
    if ((seg_use == '0) || (off_inc >= seg_use)) begin
      new_off_fast = '0;
    end else begin
      new_off_fast = OFW'(off_inc);
    end
  end

  // store address: segment sum reduced modulo the store depth
  always_comb begin
    red = RW'(addr_sum_r);
    for (int k = 2; k >= 0; k--) begin
      if (red >= (RW'(STORE_DEPTH) << k)) begin
        red = red - (RW'(STORE_DEPTH) << k);
      end
    end
    store_addr = red[AW-1:0];
  end

  // queue state write back
  always_comb begin
    qtab_we    = (state_r == S_MEM) && ok_r;
    qtab_wdata = {is_deq ? new_off_r : head_r,
                  is_enq ? new_off_r : tail_r,
                  is_enq ? occ_r + 1'b1 : occ_r - 1'b1};
  end

  assign mod_start = (state_r == S_EVAL) && need_mod;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        state_nxt = S_EVAL;
      end
      S_EVAL: state_nxt = need_mod ? S_MOD : S_MEM;
      S_MOD:  if (mod_done) begin
        state_nxt = S_MEM;
      end
      S_MEM:  state_nxt = S_DONE;
      S_DONE: if (out_load) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, configuration and running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      num_queues_r  <= NUM_QUEUES_RST;
      segment_len_r <= SEGMENT_LEN_RST;
      total_size_r  <= TOTAL_SIZE_RST;
      tot_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_QUEUES:  num_queues_r  <= cfg_wdata[NQ_W-1:0];
          REG_SEGMENT_LEN: segment_len_r <= cfg_wdata[SEG_W-1:0];
          REG_TOTAL_SIZE:  total_size_r  <= cfg_wdata[TSIZE_W-1:0];
          default: ;
        endcase
      end
      if ((state_r == S_EVAL) && ok_c) begin
        tot_r <= is_enq ? tot_r + 1'b1 : tot_r - 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request payload and intermediate results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r   <= in_req_type;
      qid_r   <= in_queue_id;
      value_r <= in_value;
    end
    if (state_r == S_EVAL) begin
      status_r   <= status_c;
      ok_r       <= ok_c;
      head_r     <= rd_head;
      tail_r     <= rd_tail;
      occ_r      <= rd_occ;
      addr_sum_r <= addr_sum_c;
      new_off_r  <= new_off_fast;
    end
    if ((state_r == S_MOD) && mod_done) begin
      new_off_r <= OFW'(mod_rem);
    end
    if (out_load) begin
      out_status_r     <= status_r;
      out_read_value_r <= (ok_r && is_deq) ? store_rd : '0;
      out_array_full_r <= (TCW'(tot_r) == TCW'(total_size_r));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_array_full = out_array_full_r;

  // queue state table
  smqb_qtab #(
    .DEPTH(MAX_QUEUES),
    .AW   (QW),
    .EW   (EW)
  ) u_qtab (
    .clk  (clk),
    .rst_n(rst_n),
    .re   (in_acc),
    .raddr(QW'(in_queue_id)),
    .rdata(qtab_rd),
    .we   (qtab_we),
    .waddr(QW'(qid_r)),
    .wdata(qtab_wdata)
  );

  // shared data store
  smqb_store #(
    .DEPTH(STORE_DEPTH),
    .AW   (AW),
    .DW   (DATA_WIDTH)
  ) u_store (
    .clk  (clk),
    .addr (store_addr),
    .we   ((state_r == S_MEM) && ok_r && is_enq),
    .wdata(value_r),
    .re   ((state_r == S_MEM) && ok_r && is_deq),
    .rdata(store_rd)
  );

  // offset wrap for offsets past a shrunken segment
  smqb_mod_unit #(
    .NW(LENW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (off_inc),
    .divisor  (seg_use),
    .done     (mod_done),
    .remainder(mod_rem)
  );

endmodule

### tb/smqb_result_checker.sv
`timescale 1ns / 100ps
// Checker for the segmented multi-queue buffer: predicts each result item
// from the accepted requests and register writes and compares it.
// Depends on smqb_pkg for codes, widths and default sizes.
module smqb_result_checker
  import smqb_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [REQ_W-1:0]                  in_req_type,
  input  logic [QID_W-1:0]                  in_queue_id,
  input  logic [DATA_WIDTH_DEF-1:0]         in_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [STATUS_W-1:0]               out_status,
  input  logic [DATA_WIDTH_DEF-1:0]         out_read_value,
  input  logic                              out_array_full,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_wdata,
  output int                                fail_count,
  output int                                pending,
  output logic [MAX_QUEUES_DEF-1:0][7:0]    queue_level
);

  localparam int DEPTH = STORE_DEPTH_DEF;
  localparam int NQ    = MAX_QUEUES_DEF;
  localparam int DW    = DATA_WIDTH_DEF;
  localparam int OFF_W = $clog2(DEPTH);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DW-1:0]       read_value;
    logic                array_full;
  } buf_result_t;

  // predicted results still on their way out of the block
  buf_result_t result_fifo[$];

  // shadow of the block state and registers
  logic [DW-1:0]      word_store [DEPTH];
  logic [OFF_W-1:0]   head_off [NQ];
  logic [OFF_W-1:0]   tail_off [NQ];
  int                 total_words;
  logic [NQ_W-1:0]    cfg_nq;
  logic [SEG_W-1:0]   cfg_seg;
  logic [TSIZE_W-1:0] cfg_total;

  // offset step inside a segment, wraps at the length in use
  function automatic logic [OFF_W-1:0] next_offset(input logic [OFF_W-1:0] off, input int len);
    return (len == 0) ? '0 : OFF_W'((off + 1) % len);
  endfunction

  // apply one request to the shadow state and return its result item
  function automatic buf_result_t apply_request(input logic [REQ_W-1:0] req,
                                                input logic [QID_W-1:0] qid,
                                                input logic [DW-1:0] value);
    buf_result_t r;
    int len;
    int q;
    int addr;
    r.status     = ST_OK;
    r.read_value = '0;
    len = (cfg_seg > DEPTH) ? DEPTH : cfg_seg;
    q   = qid;
    if (req == REQ_ENQ || req == REQ_DEQ) begin
      if (q >= cfg_nq || q >= NQ) begin
        r.status = ST_BADQ;
      end else if (req == REQ_ENQ) begin
        if (queue_level[q] >= len) begin
          r.status = ST_FULL;
        end else begin
          addr = (q * len + tail_off[q]) % DEPTH;
          word_store[addr] = value;
          tail_off[q] = next_offset(tail_off[q], len);
          queue_level[q] = queue_level[q] + 8'd1;
          total_words++;
        end
      end else begin
        if (queue_level[q] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          addr = (q * len + head_off[q]) % DEPTH;
          r.read_value = word_store[addr];
          head_off[q] = next_offset(head_off[q], len);
          queue_level[q] = queue_level[q] - 8'd1;
          total_words--;
        end
      end
    end
    r.array_full = (total_words == cfg_total);
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [DW-1:0] want,
                               input logic [DW-1:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, seen);
      fail_count++;
    end
  endtask

  // register writes, result compare, then request prediction
  always @(posedge clk) begin : track
    buf_result_t want_r;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) word_store[i] = '0;
      for (int i = 0; i < NQ; i++) begin
        head_off[i]    = '0;
        tail_off[i]    = '0;
        queue_level[i] = '0;
      end
      total_words = 0;
      cfg_nq      = NUM_QUEUES_RST;
      cfg_seg     = SEGMENT_LEN_RST;
      cfg_total   = TOTAL_SIZE_RST;
      fail_count  = 0;
      result_fifo.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_QUEUES:  cfg_nq    = cfg_wdata[NQ_W-1:0];
          REG_SEGMENT_LEN: cfg_seg   = cfg_wdata[SEG_W-1:0];
          REG_TOTAL_SIZE:  cfg_total = cfg_wdata[TSIZE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: result item with nothing outstanding, status %0d read %0h",
                   $time, out_status, out_read_value);
          fail_count++;
        end else begin
          want_r = result_fifo.pop_front();
          compare_field("status", want_r.status, out_status);
          compare_field("read_value", want_r.read_value, out_read_value);
          compare_field("array_full", want_r.array_full, out_array_full);
        end
      end
      if (in_valid && in_ready)
        result_fifo.push_back(apply_request(in_req_type, in_queue_id, in_value));
    end
    pending = result_fifo.size();
  end

endmodule

### tb/segmented_multi_queue_buffer_unit_tb.sv
`timescale 1ns / 100ps
// Top of the segmented multi-queue buffer testbench: clock, reset, request
// and register stimulus, result back-pressure, watchdog and verdict.
// Depends on smqb_pkg, the block and smqb_result_checker.
module segmented_multi_queue_buffer_unit_tb;
  import smqb_pkg::*;

  localparam int DW           = DATA_WIDTH_DEF;
  localparam int NQ           = MAX_QUEUES_DEF;
  localparam int STALL_LIMIT  = 1000;
  localparam int FLOOD_CYCLES = 120;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [REQ_W-1:0]     in_req_type;
  logic [QID_W-1:0]     in_queue_id;
  logic signed [DW-1:0] in_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  out_status;
  logic signed [DW-1:0] out_read_value;
  logic                 out_array_full;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int                   fail_count;
  int                   pending;
  logic [NQ-1:0][7:0]   queue_level;

  bit                   calm;
  bit                   flood_go;
  bit                   flood_done;
  int                   idle_cycles = 0;
  int                   cur_nq;
  int                   cur_seg;
  int                   cur_ts;

  segmented_multi_queue_buffer_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_queue_id    (in_queue_id),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_array_full (out_array_full),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  smqb_result_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_queue_id    (in_queue_id),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_array_full (out_array_full),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .queue_level    (queue_level)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result back-pressure: random bursts, one long hold, none at the end
  initial begin : sink
    out_ready = 1'b0;
    forever begin
      if (calm) begin
        out_ready = 1'b1;
        @(negedge clk);
      end else if (flood_go && !flood_done) begin
        out_ready = 1'b0;
        repeat (FLOOD_CYCLES) @(negedge clk);
        flood_done = 1'b1;
      end else begin
        out_ready = ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
    end
  end

  // offer one request item and wait for it to be taken
  task automatic send_item(input logic [REQ_W-1:0] req, input int qid, input logic [DW-1:0] val);
    if (!calm && !(flood_go && !flood_done) && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_req_type = req;
    in_queue_id = qid[QID_W-1:0];
    in_value    = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait until every result item has come back
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // write all three registers back to back
  task automatic program_regs(input int nq, input int seg, input int ts);
    logic [CFG_IDX_W-1:0]  idx_list [3];
    logic [CFG_DATA_W-1:0] data_list [3];
    idx_list[0]  = REG_NUM_QUEUES;
    idx_list[1]  = REG_SEGMENT_LEN;
    idx_list[2]  = REG_TOTAL_SIZE;
    data_list[0] = CFG_DATA_W'(nq);
    data_list[1] = CFG_DATA_W'(seg);
    data_list[2] = CFG_DATA_W'(ts);
    cfg_valid = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index = idx_list[i];
      cfg_wdata = data_list[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  // new register setting; queues are emptied first when the segment
  // length changes so no dequeue can land on a word never written
  task automatic set_layout(input int nq, input int seg, input int ts);
    logic [NQ-1:0][7:0] snap;
    settle();
    if (seg != cur_seg) begin
      snap = queue_level;
      if (snap != '0) begin
        program_regs(NQ, cur_seg, cur_ts);
        for (int q = 0; q < NQ; q++)
          repeat (snap[q]) send_item(REQ_DEQ, q, $urandom);
        settle();
      end
    end
    program_regs(nq, seg, ts);
    cur_nq  = nq;
    cur_seg = seg;
    cur_ts  = ts;
  endtask

  // random requests, in fill-heavy or drain-heavy stretches chosen at random
  task automatic random_items(input int count);
    int                 nq_used;
    bit                 fill;
    int                 r;
    int                 qid;
    logic [REQ_W-1:0]   op;
    logic [DW-1:0]      val;
    nq_used = (cur_nq > NQ) ? NQ : cur_nq;
    fill = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) fill = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 4)
        op = REQ_NOP;
      else if (r < 12)
        op = REQ_QUERY;
      else
        op = ($urandom_range(0, 99) < (fill ? 70 : 30)) ? REQ_ENQ : REQ_DEQ;
      if (nq_used == 0 || $urandom_range(0, 9) == 0)
        qid = $urandom_range(0, NQ - 1);
      else
        qid = $urandom_range(0, nq_used - 1);
      val = $urandom;
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0:       val = {1'b1, {(DW-1){1'b0}}};
          1:       val = {1'b0, {(DW-1){1'b1}}};
          2:       val = '0;
          default: val = '1;
        endcase
      end
      send_item(op, qid, val);
    end
  endtask

  // stimulus and verdict
  initial begin : stim
    in_valid    = 1'b0;
    in_req_type = REQ_NOP;
    in_queue_id = '0;
    in_value    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_NUM_QUEUES;
    cfg_wdata   = '0;
    calm        = 1'b0;
    flood_go    = 1'b0;
    flood_done  = 1'b0;
    cur_nq      = NUM_QUEUES_RST;
    cur_seg     = SEGMENT_LEN_RST;
    cur_ts      = TOTAL_SIZE_RST;
    rst_n       = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset layout: query, no-op, extreme words, bad queues, empty queue
    send_item(REQ_QUERY, 7, '1);
    send_item(REQ_NOP, 5, 32'h1234_5678);
    send_item(REQ_ENQ, 0, {1'b0, {(DW-1){1'b1}}});
    send_item(REQ_ENQ, 0, {1'b1, {(DW-1){1'b0}}});
    send_item(REQ_ENQ, 0, '0);
    send_item(REQ_ENQ, 0, '1);
    send_item(REQ_ENQ, 1, 32'hdead_beef);
    send_item(REQ_DEQ, 7, '0);
    send_item(REQ_QUERY, 0, '0);
    repeat (5) send_item(REQ_DEQ, 0, $urandom);

    // one-entry segments: queue full and whole array full
    set_layout(2, 1, 2);
    send_item(REQ_ENQ, 0, 32'h0000_0011);
    send_item(REQ_ENQ, 0, 32'h0000_0022);
    send_item(REQ_ENQ, 1, 32'h0000_0033);
    send_item(REQ_QUERY, 3, '0);
    send_item(REQ_ENQ, 1, 32'h0000_0044);
    send_item(REQ_DEQ, 1, '0);
    send_item(REQ_DEQ, 0, '0);
    send_item(REQ_DEQ, 0, '0);

    // random phases over several layouts, long result hold in the first
    set_layout(8, 16, 128);
    flood_go = 1'b1;
    random_items(220);
    set_layout(2, 16, 128);
    random_items(100);
    set_layout(4, 4, 16);
    random_items(150);
    set_layout(2, 1, 2);
    random_items(80);
    set_layout(8, 0, 0);
    random_items(30);
    set_layout(3, 255, 255);
    random_items(120);
    set_layout(15, 10, 80);
    random_items(150);
    set_layout(0, 5, 0);
    random_items(20);
    set_layout(5, 7, 35);
    random_items(130);
    set_layout(1, 128, 128);
    calm = 1'b1;
    random_items(60);

    // drain and decide
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/smqb_pkg.sv
rtl/smqb_qtab.sv
rtl/smqb_store.sv
rtl/smqb_mod_unit.sv
rtl/segmented_multi_queue_buffer_unit.sv
tb/smqb_result_checker.sv
tb/segmented_multi_queue_buffer_unit_tb.sv
